[rtl/sps_pkg.sv]
package sps_pkg;

  localparam int CMD_W       = 2;
  localparam int DEG_W       = 16;
  localparam int SPR_W       = 14;
  localparam int IVL_W       = 9;
  localparam int STEPS_W     = 20;
  localparam int ELAPSED_W   = 10;
  localparam int PROD_W      = 29;
  localparam int QUOT_W      = 21;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_SPR      = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [SPR_W-1:0]     SPR_MAX      = 14'd8192;
  localparam logic [SPR_W-1:0]     SPR_RESET    = 14'd200;
  localparam logic [IVL_W-1:0]     IVL_MAX      = 9'd500;
  localparam logic [IVL_W-1:0]     IVL_RESET    = 9'd10;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 10'd1023;

  // 360 = 8 * 45: shift by three, then multiply by floor(2^32 / 45)
  localparam int               DIV_SHIFT = 3;
  localparam int               RECIP_SH  = 32;
  localparam logic [26:0]      RECIP     = 27'd95443717;
  localparam logic [26:0]      DIV_ODD   = 27'd45;

  typedef struct packed {
    logic                 half_step_mode;
    logic [SPR_W-1:0]     steps_per_rev;
    logic [IVL_W-1:0]     step_interval;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               fwd;
    logic [STEPS_W-1:0] steps;
  } item_t;

endpackage

[rtl/sps_regs.sv]
module sps_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sps_pkg::ADDR_W-1:0]    paddr,
  input  logic [sps_pkg::DATA_W-1:0]    pwdata,
  output logic [sps_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output sps_pkg::cfg_t                 cfg
);
  import sps_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             wr;
  logic [1:0]       idx;
  logic [SPR_W-1:0] spr_w;
  logic [IVL_W-1:0] ivl_w;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign spr_w  = pwdata[SPR_W-1:0];
  assign ivl_w  = pwdata[IVL_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_MODE:     cfg_nxt.half_step_mode = pwdata[0];
        REG_SPR:      cfg_nxt.steps_per_rev  = (spr_w > SPR_MAX) ? SPR_MAX : spr_w;
        REG_INTERVAL: cfg_nxt.step_interval  = (ivl_w > IVL_MAX) ? IVL_MAX : ivl_w;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_step_mode <= 1'b1;
      cfg_r.steps_per_rev  <= SPR_RESET;
      cfg_r.step_interval  <= IVL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:     prdata = {{(DATA_W-1){1'b0}}, cfg_r.half_step_mode};
      REG_SPR:      prdata = {{(DATA_W-SPR_W){1'b0}}, cfg_r.steps_per_rev};
      REG_INTERVAL: prdata = {{(DATA_W-IVL_W){1'b0}}, cfg_r.step_interval};
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[rtl/sps_scale.sv]
module sps_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [sps_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [sps_pkg::DEG_W-1:0] in_degree,
  input  logic [sps_pkg::SPR_W-1:0]     spr,
  output logic                          item_valid,
  output sps_pkg::item_t                item
);
  import sps_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic [CMD_W-1:0]   cmd1_r, cmd2_r, cmd3_r;
  logic               fwd1_r, fwd2_r, fwd3_r;
  logic [PROD_W-1:0]  prod_r;
  logic [25:0]        y_r;
  logic [QUOT_W-1:0]  est_r;
  logic [STEPS_W-1:0] steps_r;

  logic               neg;
  logic [DEG_W-1:0]   mag;
  logic [29:0]        prod_full;
  logic [25:0]        y_w;
  logic [52:0]        est_full;
  logic [26:0]        est_x;
  logic [26:0]        rem;
  logic [STEPS_W-1:0] steps_nxt;

  assign neg       = in_degree[DEG_W-1];
  assign mag       = neg ? (~in_degree + 16'd1) : in_degree;
  assign prod_full = spr * mag;

  assign y_w       = prod_r[PROD_W-1:DIV_SHIFT];
  assign est_full  = y_w * RECIP;

  assign est_x     = {6'b0, est_r} * DIV_ODD;
  assign rem       = {1'b0, y_r} - est_x;
  assign steps_nxt = est_r[STEPS_W-1:0] + STEPS_W'(rem >= DIV_ODD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= in_cmd;
      fwd1_r  <= !neg && (in_degree != '0);
      prod_r  <= prod_full[PROD_W-1:0];
      cmd2_r  <= cmd1_r;
      fwd2_r  <= fwd1_r;
      y_r     <= y_w;
      est_r   <= est_full[RECIP_SH+QUOT_W-1:RECIP_SH];
      cmd3_r  <= cmd2_r;
      fwd3_r  <= fwd2_r;
      steps_r <= steps_nxt;
    end
  end

  assign item_valid = v3_r;
  assign item.cmd   = cmd3_r;
  assign item.fwd   = fwd3_r;
  assign item.steps = steps_r;

endmodule

[rtl/sps_core.sv]
module sps_core #(
  parameter int NUM_COILS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           item_valid,
  input  sps_pkg::item_t                 item,
  input  sps_pkg::cfg_t                  cfg,
  output logic                           out_valid,
  output logic [NUM_COILS-1:0]           out_coils,
  output logic                           out_stepped,
  output logic                           out_busy_res,
  output logic [sps_pkg::STEPS_W-1:0]    out_remaining
);
  import sps_pkg::*;

  localparam int PW = $clog2(NUM_COILS);

  logic [PW-1:0]        phase_r, phase_nxt;
  logic                 half_r, half_nxt;
  logic [STEPS_W-1:0]   steps_left_r, steps_left_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [NUM_COILS-1:0] pat_r, pat_nxt;

  logic                 ov_r;
  logic [NUM_COILS-1:0] coils_r;
  logic                 stepped_r;
  logic                 busy_r;
  logic [STEPS_W-1:0]   rem_r;

  logic                 upd;
  logic                 step_w;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [PW-1:0]        rot;

  assign upd         = adv && item_valid;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_r + 1'b1;
  assign rot         = fwd_r ? phase_r + 1'b1 : phase_r - 1'b1;
  assign step_w      = (item.cmd == CMD_TICK) && (elapsed_inc > {1'b0, cfg.step_interval})
                       && (steps_left_r != '0);

  always_comb begin
    phase_nxt      = phase_r;
    half_nxt       = half_r;
    steps_left_nxt = steps_left_r;
    fwd_nxt        = fwd_r;
    elapsed_nxt    = elapsed_r;
    pat_nxt        = pat_r;
    case (item.cmd)
      CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (step_w) begin
          elapsed_nxt    = '0;
          steps_left_nxt = steps_left_r - 1'b1;
          pat_nxt        = NUM_COILS'(1) << phase_r;
          if (cfg.half_step_mode) begin
            if (!half_r) begin
              half_nxt = 1'b1;
            end else begin
              pat_nxt   = pat_nxt | (NUM_COILS'(1) << rot);
              half_nxt  = 1'b0;
              phase_nxt = rot;
            end
          end else begin
            phase_nxt = rot;
          end
        end
      end
      CMD_MOVE: begin
        if (steps_left_r == '0) begin
          steps_left_nxt = item.steps;
          fwd_nxt        = item.fwd;
          elapsed_nxt    = '0;
        end
      end
      CMD_STOP: steps_left_nxt = '0;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      half_r       <= 1'b0;
      steps_left_r <= '0;
      fwd_r        <= 1'b0;
      elapsed_r    <= '0;
      pat_r        <= '0;
      ov_r         <= 1'b0;
    end else begin
      if (adv) begin
        ov_r <= item_valid;
      end
      if (upd) begin
        phase_r      <= phase_nxt;
        half_r       <= half_nxt;
        steps_left_r <= steps_left_nxt;
        fwd_r        <= fwd_nxt;
        elapsed_r    <= elapsed_nxt;
        pat_r        <= pat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      coils_r   <= pat_nxt;
      stepped_r <= step_w;
      busy_r    <= steps_left_nxt != '0;
      rem_r     <= steps_left_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_coils     = coils_r;
  assign out_stepped   = stepped_r;
  assign out_busy_res  = busy_r;
  assign out_remaining = rem_r;

  a_coil_count: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $countones(coils_r) <= 2)
    else $error("more than two coils driven");

  a_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    upd && (item.cmd != CMD_MOVE) |=> steps_left_r <= $past(steps_left_r))
    else $error("step count grew without a move");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(steps_left_r) && $stable(phase_r) && $stable(pat_r))
    else $error("state changed without a transfer");

endmodule

[rtl/stepper_phase_sequencer_unit.sv]
// Pipeline: a result follows its input transfer through four register stages.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// The pipeline is set by the three multiplies of the degree-to-steps scaling.
// Reset (rst_n low, synchronous): pipeline empty, sequencer state cleared,
// registers back to half stepping, 200 steps per revolution, interval 10.
module stepper_phase_sequencer_unit #(
  parameter int NUM_COILS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sps_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [sps_pkg::DEG_W-1:0] in_degree,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [NUM_COILS-1:0]             out_coils,
  output logic                             out_stepped,
  output logic                             out_busy_res,
  output logic [sps_pkg::STEPS_W-1:0]      out_remaining,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sps_pkg::ADDR_W-1:0]       paddr,
  input  logic [sps_pkg::DATA_W-1:0]       pwdata,
  output logic [sps_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import sps_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  sps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sps_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_degree  (in_degree),
    .spr        (cfg.steps_per_rev),
    .item_valid (item_valid),
    .item       (item)
  );

  sps_core #(
    .NUM_COILS (NUM_COILS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .item_valid    (item_valid),
    .item          (item),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_coils     (out_coils),
    .out_stepped   (out_stepped),
    .out_busy_res  (out_busy_res),
    .out_remaining (out_remaining)
  );

endmodule

[tb/testbench.sv]
module testbench;
  import sps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int TIMEOUT_CYCLES = 200000;

  class coil_scoreboard;
    typedef struct {
      logic [3:0]         coils;
      logic               stepped;
      logic               busy;
      logic [STEPS_W-1:0] remaining;
    } drive_state_t;

    drive_state_t predicted_drive_q[$];

    logic                 half_mode;
    logic [SPR_W-1:0]     spr_cfg;
    logic [IVL_W-1:0]     interval_cfg;

    logic [1:0]           rotor_idx;
    logic                 mid_step;
    logic [STEPS_W-1:0]   steps_to_go;
    logic                 dir_fwd;
    logic [ELAPSED_W-1:0] ms_count;
    logic [3:0]           coil_drive;

    int errors;

    function new();
      half_mode    = 1'b1;
      spr_cfg      = SPR_RESET;
      interval_cfg = IVL_RESET;
      rotor_idx    = '0;
      mid_step     = 1'b0;
      steps_to_go  = '0;
      dir_fwd      = 1'b0;
      ms_count     = '0;
      coil_drive   = '0;
      errors       = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_MODE: half_mode = val[0];
        REG_SPR: spr_cfg = (val[SPR_W-1:0] > SPR_MAX) ? SPR_MAX : val[SPR_W-1:0];
        REG_INTERVAL: interval_cfg = (val[IVL_W-1:0] > IVL_MAX) ? IVL_MAX : val[IVL_W-1:0];
        default: ;
      endcase
    endfunction

    function void step_rotor();
      logic [3:0] pat;
      logic [1:0] nxt;
      pat = 4'b0001 << rotor_idx;
      nxt = dir_fwd ? rotor_idx + 2'd1 : rotor_idx - 2'd1;
      if (half_mode) begin
        if (!mid_step) begin
          mid_step = 1'b1;
        end else begin
          pat = pat | (4'b0001 << nxt);
          mid_step = 1'b0;
          rotor_idx = nxt;
        end
      end else begin
        rotor_idx = nxt;
      end
      coil_drive = pat;
    endfunction

    function void note_transfer(logic [CMD_W-1:0] cmd, logic signed [DEG_W-1:0] deg);
      drive_state_t exp_drive;
      longint mag;
      longint prod;
      logic stepped;
      stepped = 1'b0;
      case (cmd)
        CMD_TICK: begin
          if (ms_count < ELAPSED_MAX) ms_count = ms_count + 1'b1;
          if (ms_count > interval_cfg && steps_to_go != 0) begin
            ms_count = '0;
            steps_to_go = steps_to_go - 1'b1;
            step_rotor();
            stepped = 1'b1;
          end
        end
        CMD_MOVE: begin
          if (steps_to_go == 0) begin
            mag = (deg < 0) ? -longint'(deg) : longint'(deg);
            prod = longint'(spr_cfg) * mag;
            steps_to_go = STEPS_W'(prod / 360);
            dir_fwd = (deg > 0);
            ms_count = '0;
          end
        end
        CMD_STOP: steps_to_go = '0;
        default: ;
      endcase
      exp_drive.coils     = coil_drive;
      exp_drive.stepped   = stepped;
      exp_drive.busy      = (steps_to_go != 0);
      exp_drive.remaining = steps_to_go;
      predicted_drive_q.push_back(exp_drive);
    endfunction

    function void check_result(logic [3:0] coils, logic stepped, logic busy,
                               logic [STEPS_W-1:0] remaining);
      drive_state_t exp_drive;
      if (predicted_drive_q.size() == 0) begin
        $display("%0t: unexpected transfer: coils %h stepped %b busy %b remaining %0d",
                 $time, coils, stepped, busy, remaining);
        errors++;
        return;
      end
      exp_drive = predicted_drive_q.pop_front();
      if (coils !== exp_drive.coils) begin
        $display("%0t: coils expected %h, got %h", $time, exp_drive.coils, coils);
        errors++;
      end
      if (stepped !== exp_drive.stepped) begin
        $display("%0t: stepped expected %b, got %b", $time, exp_drive.stepped, stepped);
        errors++;
      end
      if (busy !== exp_drive.busy) begin
        $display("%0t: busy_res expected %b, got %b", $time, exp_drive.busy, busy);
        errors++;
      end
      if (remaining !== exp_drive.remaining) begin
        $display("%0t: remaining expected %0d, got %0d", $time, exp_drive.remaining,
                 remaining);
        errors++;
      end
    endfunction

    function int outstanding();
      return predicted_drive_q.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_cmd;
  logic signed [DEG_W-1:0]   in_degree;
  logic                      out_valid;
  logic                      out_ready;
  logic [3:0]                out_coils;
  logic                      out_stepped;
  logic                      out_busy_res;
  logic [STEPS_W-1:0]        out_remaining;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  coil_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 0;
  bit valid_up = 1'b0;
  bit hold_requested = 1'b0;
  bit hold_active = 1'b0;
  bit hold_done = 1'b0;

  stepper_phase_sequencer_unit #(.NUM_COILS(4)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_degree(in_degree),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_coils(out_coils),
    .out_stepped(out_stepped),
    .out_busy_res(out_busy_res),
    .out_remaining(out_remaining),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("stepper_phase_sequencer_unit verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_transfer(in_cmd, in_degree);
      if (out_valid && out_ready) begin
        sb.check_result(out_coils, out_stepped, out_busy_res, out_remaining);
      end
    end
  end

  initial begin
    int seg;
    int mode;
    int k;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      seg = $urandom_range(10, 120);
      mode = $urandom_range(0, 2);
      for (k = 0; k < seg; k++) begin
        @(negedge clk);
        if (hold_requested && !hold_done) begin
          out_ready <= 1'b0;
          hold_active = 1'b1;
          repeat (90) @(negedge clk);
          hold_active = 1'b0;
          hold_done = 1'b1;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (k % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [DEG_W-1:0] d);
    if (!(c == CMD_MOVE && sb.steps_to_go != 0)) items_sent++;
    if (items_sent >= 300) hold_requested = 1'b1;
    if (burst_left == 0) begin
      if (!hold_active) begin
        if (valid_up) begin
          in_valid <= 1'b0;
          valid_up = 1'b0;
        end
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    valid_up  = 1'b1;
    in_cmd    <= c;
    in_degree <= d;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, val);
    @(negedge clk);
  endtask

  task automatic reprogram(input logic mode, input int spr, input int ivl);
    drop_valid();
    while (sb.outstanding() != 0) @(negedge clk);
    cfg_write(REG_MODE, DATA_W'(mode));
    cfg_write(REG_SPR, DATA_W'(spr));
    cfg_write(REG_INTERVAL, DATA_W'(ivl));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_burst();
    int kind;
    int max_steps;
    int deg_lim;
    int n_ticks;
    int cut_at;
    int i;
    logic signed [DEG_W-1:0] d;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if (sb.steps_to_go != 0) send_item(CMD_STOP, DEG_W'($urandom));
      max_steps = (sb.interval_cfg >= 100) ? 1 : 6;
      if (sb.spr_cfg == 0) deg_lim = 32767;
      else deg_lim = (360 * (max_steps + 1) - 1) / int'(sb.spr_cfg);
      if (deg_lim > 32767) deg_lim = 32767;
      d = DEG_W'($urandom_range(0, deg_lim));
      if ($urandom_range(0, 1)) d = -d;
      send_item(CMD_MOVE, d);
      n_ticks = int'(sb.steps_to_go) * (int'(sb.interval_cfg) + 1) + $urandom_range(0, 3);
      cut_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_ticks) : -1;
      for (i = 0; i < n_ticks; i++) begin
        if (i == cut_at) begin
          send_item(CMD_STOP, DEG_W'($urandom));
        end else if ($urandom_range(0, 19) == 0) begin
          send_item((sb.steps_to_go != 0) ? CMD_MOVE : CMD_SPARE, DEG_W'($urandom));
        end else begin
          send_item(CMD_TICK, DEG_W'($urandom));
        end
      end
    end else if (kind < 80) begin
      if (sb.steps_to_go != 0) send_item(CMD_STOP, DEG_W'($urandom));
      send_item(CMD_MOVE, DEG_W'($urandom));
      repeat ($urandom_range(1, 15)) send_item(CMD_TICK, DEG_W'($urandom));
      send_item(CMD_STOP, DEG_W'($urandom));
    end else if (kind < 90) begin
      send_item(CMD_W'($urandom_range(0, 3)), DEG_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) send_item(CMD_TICK, DEG_W'($urandom));
    end
  endtask

  task automatic run_phase(input int budget);
    int target;
    target = items_sent + budget;
    while (items_sent < target) run_burst();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = CMD_TICK;
    in_degree = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(CMD_TICK, 16'sh0000);
    send_item(CMD_MOVE, 16'sh0000);
    send_item(CMD_MOVE, 16'sh7FFF);
    send_item(CMD_MOVE, -16'sd5);
    send_item(CMD_SPARE, 16'shFFFF);
    send_item(CMD_STOP, 16'sh5555);
    send_item(CMD_MOVE, 16'sh8000);
    send_item(CMD_TICK, 16'shAAAA);
    send_item(CMD_STOP, 16'sh0000);
    send_item(CMD_MOVE, 16'sd9);
    repeat (12) send_item(CMD_TICK, 16'sh7FFF);
    send_item(CMD_TICK, 16'sh8000);

    reprogram(1'b0, 8192, 0);
    run_phase(150);
    reprogram(1'b1, 0, 3);
    run_phase(150);
    reprogram(1'b1, 1, 1);
    run_phase(150);
    reprogram(1'b0, 16383, 2);
    run_phase(150);
    reprogram(1'b1, 360, 511);
    run_phase(250);
    reprogram(1'b0, 200, 5);
    run_phase(150);
    reprogram(1'b1, 9999, 0);
    run_phase(150);
    reprogram(1'b1, 48, 1);
    run_phase(150);

    drop_valid();
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("stepper_phase_sequencer_unit verification clean");
    end else begin
      $display("stepper_phase_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
